// ===== hw/rtl/regression_tree_leaf_lookup_macros.svh =====
// Assertion macros for the regression tree leaf lookup block.
`ifndef REGRESSION_TREE_LEAF_LOOKUP_MACROS_SVH
`define REGRESSION_TREE_LEAF_LOOKUP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define RTLL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define RTLL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RTLL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RTLL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/rtll_pkg.sv =====
// Types and constants shared by the regression tree leaf lookup block.
package rtll_pkg;

	localparam int MAX_DEPTH      = 5;
	localparam int NUM_PIXELS     = 512;
	localparam int MAX_LANDMARKS  = 128;
	localparam int NODE_COUNT     = (1 << MAX_DEPTH) - 1;
	localparam int WORDS_PER_NODE = 3 * MAX_LANDMARKS;
	localparam int RES_DEPTH      = NODE_COUNT * WORDS_PER_NODE;

	localparam int NODE_AW  = $clog2(NODE_COUNT);
	localparam int PIX_AW   = $clog2(NUM_PIXELS);
	localparam int RES_AW   = $clog2(RES_DEPTH);
	localparam int WORDS_W  = $clog2(WORDS_PER_NODE + 1);
	localparam int LM_W     = $clog2(MAX_LANDMARKS + 1);
	localparam int DEPTH_W  = $clog2(MAX_DEPTH + 1);

	localparam logic [2:0] CMD_WR_NODE  = 3'd0;
	localparam logic [2:0] CMD_WR_RES   = 3'd1;
	localparam logic [2:0] CMD_WR_PIX   = 3'd2;
	localparam logic [2:0] CMD_PREDICT  = 3'd3;
	localparam logic [2:0] CMD_RD_RES   = 3'd4;

	localparam logic [1:0] REG_TREE_DEPTH     = 2'd0;
	localparam logic [1:0] REG_LANDMARK_COUNT = 2'd1;

	localparam logic KIND_PREDICT = 1'b0;
	localparam logic KIND_READ    = 1'b1;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [4:0]         node_index;
		logic               leaf_mark;
		logic [8:0]         first_pixel;
		logic [8:0]         second_pixel;
		logic signed [15:0] split_threshold;
		logic [8:0]         pixel_index;
		logic [15:0]        intensity_value;
		logic [8:0]         element_index;
		logic signed [31:0] residual_word;
	} rtll_in_t;

	typedef struct packed {
		logic               kind;
		logic [4:0]         leaf_node;
		logic signed [31:0] residual_value;
		logic               range_error;
	} rtll_out_t;

	typedef struct packed {
		logic               leaf;
		logic [8:0]         pix_a;
		logic [8:0]         pix_b;
		logic signed [15:0] thr;
	} rtll_node_t;

endpackage

// ===== hw/rtl/regression_tree_leaf_lookup.sv =====
// Top level of the regression tree leaf lookup block: loads, tree walk and residual reads.
`include "regression_tree_leaf_lookup_macros.svh"

// Items are taken when start is high and busy is low; each result appears for one
// cycle with done high and cannot be held off. Node, residual and intensity writes
// give no result. A read of a residual word registers the stored word and then the
// result. A predict walks the tree with one node memory read port and one intensity
// read port shared by both pixels of a test: each level steps through node read,
// first intensity, second intensity and compare, and the result follows the last
// level, sooner when a leaf mark ends the walk. The configuration port is always
// ready; write it only while the block is idle.
module regression_tree_leaf_lookup (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  rtll_pkg::rtll_in_t   item,
	output logic                 done,
	output rtll_pkg::rtll_out_t  result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_NODE = 3'd1;
	localparam logic [2:0] ST_PIXA = 3'd2;
	localparam logic [2:0] ST_PIXB = 3'd3;
	localparam logic [2:0] ST_CMP  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_RRES = 3'd6;

	logic [2:0]                    state_q;
	logic [2:0]                    depth_q;
	logic [7:0]                    lm_q;
	logic [rtll_pkg::NODE_AW-1:0]  n_q;
	logic [rtll_pkg::NODE_AW-1:0]  reached_q;
	logic [rtll_pkg::DEPTH_W-1:0]  cnt_q;
	logic [15:0]                   a_q;
	logic                          pix_ok_q;
	logic                          range_q;
	logic                          done_q;
	rtll_pkg::rtll_out_t           result_q;

	rtll_pkg::rtll_node_t          node_mem [rtll_pkg::NODE_COUNT];
	logic [15:0]                   pix_mem  [rtll_pkg::NUM_PIXELS];
	logic [31:0]                   res_mem  [rtll_pkg::RES_DEPTH];
	rtll_pkg::rtll_node_t          node_rd_q;
	logic [15:0]                   pix_rd_q;
	logic [31:0]                   res_rd_q;

	logic                          accept;
	logic [rtll_pkg::DEPTH_W-1:0]  depth_eff;
	logic [rtll_pkg::LM_W-1:0]     lm_eff;
	logic [rtll_pkg::WORDS_W-1:0]  words_used;
	logic                          elem_ok;
	logic                          node_ok;
	logic [rtll_pkg::RES_AW-1:0]   res_waddr;
	logic [rtll_pkg::RES_AW-1:0]   res_raddr;
	logic [8:0]                    pix_sel;
	logic                          pix_sel_ok;
	logic [15:0]                   pix_b_val;
	logic signed [16:0]            diff;
	logic signed [16:0]            thr_ext;
	logic [rtll_pkg::NODE_AW:0]    child;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	// Clamp configuration to its usable range
	always_comb begin
		if (depth_q == 3'd0) begin
			depth_eff = rtll_pkg::DEPTH_W'(1);
		end else if (32'(depth_q) > rtll_pkg::MAX_DEPTH) begin
			depth_eff = rtll_pkg::DEPTH_W'(rtll_pkg::MAX_DEPTH);
		end else begin
			depth_eff = rtll_pkg::DEPTH_W'(depth_q);
		end
		if (32'(lm_q) > rtll_pkg::MAX_LANDMARKS) begin
			lm_eff = rtll_pkg::LM_W'(rtll_pkg::MAX_LANDMARKS);
		end else begin
			lm_eff = rtll_pkg::LM_W'(lm_q);
		end
	end

	assign words_used = rtll_pkg::WORDS_W'(lm_eff) * rtll_pkg::WORDS_W'(3);
	assign elem_ok    = rtll_pkg::WORDS_W'(item.element_index) < words_used
		&& 32'(item.element_index) < rtll_pkg::WORDS_PER_NODE;
	assign node_ok    = 32'(item.node_index) < rtll_pkg::NODE_COUNT;

	// Flat residual addresses for writes (addressed node) and reads (reached node)
	assign res_waddr = rtll_pkg::RES_AW'(item.node_index[rtll_pkg::NODE_AW-1:0])
		* rtll_pkg::RES_AW'(rtll_pkg::WORDS_PER_NODE)
		+ rtll_pkg::RES_AW'(item.element_index);
	assign res_raddr = rtll_pkg::RES_AW'(reached_q)
		* rtll_pkg::RES_AW'(rtll_pkg::WORDS_PER_NODE)
		+ rtll_pkg::RES_AW'(item.element_index);

	// Select which intensity of the current node to fetch
	assign pix_sel    = (state_q == ST_PIXA) ? node_rd_q.pix_a : node_rd_q.pix_b;
	assign pix_sel_ok = 32'(pix_sel) < rtll_pkg::NUM_PIXELS;

	// Shared compare: difference of intensities against threshold
	assign pix_b_val = pix_ok_q ? pix_rd_q : 16'd0;
	assign diff      = $signed({1'b0, a_q}) - $signed({1'b0, pix_b_val});
	assign thr_ext   = 17'(node_rd_q.thr);
	assign child     = (rtll_pkg::NODE_AW + 1)'({n_q, 1'b0})
		+ ((diff > thr_ext) ? (rtll_pkg::NODE_AW + 1)'(1) : (rtll_pkg::NODE_AW + 1)'(2));

	// Node table: write on transfer, registered read of the walk node
	always_ff @(posedge clk) begin
		if (accept && item.cmd == rtll_pkg::CMD_WR_NODE && node_ok) begin
			node_mem[item.node_index[rtll_pkg::NODE_AW-1:0]] <= '{
				leaf:  item.leaf_mark,
				pix_a: item.first_pixel,
				pix_b: item.second_pixel,
				thr:   item.split_threshold
			};
		end
		node_rd_q <= node_mem[n_q];
	end

	// Intensity store: one port shared by both pixels of a test
	always_ff @(posedge clk) begin
		if (accept && item.cmd == rtll_pkg::CMD_WR_PIX
				&& 32'(item.pixel_index) < rtll_pkg::NUM_PIXELS) begin
			pix_mem[item.pixel_index[rtll_pkg::PIX_AW-1:0]] <= item.intensity_value;
		end
		pix_rd_q <= pix_mem[pix_sel[rtll_pkg::PIX_AW-1:0]];
	end

	// Residual store: write on transfer, read addressed at the read transfer
	always_ff @(posedge clk) begin
		if (accept && item.cmd == rtll_pkg::CMD_WR_RES && node_ok && elem_ok) begin
			res_mem[res_waddr] <= item.residual_word;
		end
		res_rd_q <= res_mem[res_raddr];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= 3'd5;
			lm_q    <= 8'd68;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rtll_pkg::REG_TREE_DEPTH:     depth_q <= cfg_data[2:0];
				rtll_pkg::REG_LANDMARK_COUNT: lm_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer: walk levels, then deliver the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			n_q       <= '0;
			reached_q <= '0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && item.cmd == rtll_pkg::CMD_PREDICT) begin
						n_q   <= '0;
						cnt_q <= depth_eff - rtll_pkg::DEPTH_W'(1);
						state_q <= (depth_eff == rtll_pkg::DEPTH_W'(1)) ? ST_FIN : ST_NODE;
					end else if (accept && item.cmd == rtll_pkg::CMD_RD_RES) begin
						state_q <= ST_RRES;
					end
				end
				ST_NODE: state_q <= ST_PIXA;
				ST_PIXA: state_q <= node_rd_q.leaf ? ST_FIN : ST_PIXB;
				ST_PIXB: state_q <= ST_CMP;
				ST_CMP: begin
					n_q   <= child[rtll_pkg::NODE_AW-1:0];
					cnt_q <= cnt_q - rtll_pkg::DEPTH_W'(1);
					state_q <= (cnt_q == rtll_pkg::DEPTH_W'(1)) ? ST_FIN : ST_NODE;
				end
				ST_FIN: begin
					reached_q <= n_q;
					done_q    <= 1'b1;
					state_q   <= ST_IDLE;
				end
				ST_RRES: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the walk and the read
	always_ff @(posedge clk) begin
		if (state_q == ST_PIXA || state_q == ST_PIXB) begin
			pix_ok_q <= pix_sel_ok;
		end
		if (state_q == ST_PIXB) begin
			a_q <= pix_ok_q ? pix_rd_q : 16'd0;
		end
		if (accept) begin
			range_q <= !(elem_ok && 32'(reached_q) < rtll_pkg::NODE_COUNT);
		end
	end

	// Result register, valid for the cycle that done marks
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			result_q.kind           <= rtll_pkg::KIND_PREDICT;
			result_q.leaf_node      <= 5'(n_q);
			result_q.residual_value <= '0;
			result_q.range_error    <= 1'b0;
		end else if (state_q == ST_RRES) begin
			result_q.kind           <= rtll_pkg::KIND_READ;
			result_q.leaf_node      <= 5'(reached_q);
			result_q.residual_value <= range_q ? 32'sd0 : $signed(res_rd_q);
			result_q.range_error    <= range_q;
		end
	end

	`RTLL_ASSERT_NEXT(a_result_cmd_busy, clk, arst_n, start && !busy && (item.cmd == rtll_pkg::CMD_PREDICT || item.cmd == rtll_pkg::CMD_RD_RES), busy)
	`RTLL_ASSERT_NOW(a_done_after_busy, clk, arst_n, done, $past(busy))
	`RTLL_ASSERT_NOW(a_predict_clean, clk, arst_n, done && result.kind == rtll_pkg::KIND_PREDICT, result.residual_value == 0 && !result.range_error)
	`RTLL_ASSERT_NOW(a_range_zero, clk, arst_n, done && result.range_error, result.residual_value == 0 && result.kind == rtll_pkg::KIND_READ)

endmodule
